// ===== design/utf8d_pkg.sv =====
// utf8d_pkg: shared widths, command kinds and the classified-request struct
// for the UTF-8 stream decoder. No dependencies.

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 31;
  localparam int CNT_W  = 3;
  localparam int VAL_W  = 7;

  // Lead-byte payload masks and the continuation mask
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_LEAD5 = 8'h03;
  localparam logic [BYTE_W-1:0] MASK_LEAD6 = 8'h01;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'h3F;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_EMIT = 2'd0;  // single-byte result (ASCII or invalid)
  localparam kind_t KIND_LEAD = 2'd1;  // opens a sequence
  localparam kind_t KIND_CONT = 2'd2;  // continuation byte

  typedef struct packed {
    kind_t             kind;
    logic [VAL_W-1:0]  value;  // ASCII byte, lead payload or low six bits
    logic [CNT_W-1:0]  len;    // sequence length for LEAD, 1 for EMIT
    logic              last;   // final continuation of the sequence
  } utf8d_cmd_t;

endpackage

// ===== design/utf8d_ifs.sv =====
// utf8d_ifs: valid/ready channel interfaces for the byte input and the
// code point output. Depends on utf8d_pkg.

interface utf8d_in_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8d_out_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::CP_W-1:0]    code_point;
  logic [utf8d_pkg::CNT_W-1:0]   byte_count;

  modport source (output valid, output code_point, output byte_count, input ready);
  modport sink   (input valid, input code_point, input byte_count, output ready);
endinterface

// ===== design/utf8d_front.sv =====
// utf8d_front: accepts raw bytes, tracks how many continuations are due and
// turns each byte into a classified request. Depends on utf8d_pkg.

module utf8d_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_vld,
  input  logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
  input  logic                          q_full,
  output logic                          byte_rdy,
  output logic                          push,
  output utf8d_pkg::utf8d_cmd_t         cmd
);
  import utf8d_pkg::*;

  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] lead_len;
  logic [BYTE_W-1:0] lead_val;
  logic              lead_ok;

  assign byte_rdy = !q_full;
  assign push     = byte_vld && !q_full;

  always_comb begin
    lead_ok  = 1'b1;
    lead_len = CNT_W'(2);
    lead_val = byte_in & MASK_LEAD2;
    if (!byte_in[5]) begin
      lead_len = CNT_W'(2);
      lead_val = byte_in & MASK_LEAD2;
    end else if (!byte_in[4]) begin
      lead_len = CNT_W'(3);
      lead_val = byte_in & MASK_LEAD3;
    end else if (!byte_in[3]) begin
      lead_len = CNT_W'(4);
      lead_val = byte_in & MASK_LEAD4;
    end else if (!byte_in[2]) begin
      lead_len = CNT_W'(5);
      lead_val = byte_in & MASK_LEAD5;
    end else if (!byte_in[1]) begin
      lead_len = CNT_W'(6);
      lead_val = byte_in & MASK_LEAD6;
    end else begin
      lead_ok  = 1'b0;  // 0xFE / 0xFF
    end
  end

  always_comb begin
    rem_nxt   = rem_r;
    cmd.kind  = KIND_EMIT;
    cmd.value = '0;
    cmd.len   = CNT_W'(1);
    cmd.last  = 1'b0;
    if (rem_r != '0) begin
      // inside a sequence every byte counts as a continuation
      cmd.kind  = KIND_CONT;
      cmd.value = VAL_W'(byte_in & MASK_CONT);
      cmd.last  = (rem_r == CNT_W'(1));
      rem_nxt   = rem_r - CNT_W'(1);
    end else if (!byte_in[7]) begin
      cmd.value = byte_in[VAL_W-1:0];
    end else if (byte_in[6] && lead_ok) begin
      cmd.kind  = KIND_LEAD;
      cmd.value = lead_val[VAL_W-1:0];
      cmd.len   = lead_len;
      rem_nxt   = lead_len - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (push) begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== design/utf8d_queue.sv =====
// utf8d_queue: small register queue of classified requests between the
// front and the back. Depends on utf8d_pkg.

module utf8d_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  utf8d_pkg::utf8d_cmd_t  push_cmd,
  input  logic                   pop,
  output logic                   full,
  output logic                   head_vld,
  output utf8d_pkg::utf8d_cmd_t  head_cmd
);
  import utf8d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utf8d_cmd_t     mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign full     = (cnt_r == CW'(DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/utf8d_back.sv =====
// utf8d_back: executes classified requests, gathers the code point and holds
// the result in an output register. Depends on utf8d_pkg.

module utf8d_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_vld,
  input  utf8d_pkg::utf8d_cmd_t         head_cmd,
  output logic                          pop,
  output logic                          res_vld,
  input  logic                          res_rdy,
  output logic [utf8d_pkg::CP_W-1:0]    res_cp,
  output logic [utf8d_pkg::CNT_W-1:0]   res_cnt
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0] len_r;
  logic             out_vld_r;
  logic [CP_W-1:0]  cp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             needs_out;

  assign needs_out = (head_cmd.kind == KIND_EMIT) ||
                     (head_cmd.kind == KIND_CONT && head_cmd.last);
  // a request that produces nothing never waits on the output side
  assign pop     = head_vld && (!needs_out || !out_vld_r || res_rdy);
  assign acc_nxt = {acc_r[CP_W-7:0], head_cmd.value[5:0]};

  assign res_vld = out_vld_r;
  assign res_cp  = cp_r;
  assign res_cnt = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pop && needs_out) begin
      out_vld_r <= 1'b1;
    end else if (res_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head_cmd.kind)
        KIND_EMIT: begin
          cp_r  <= CP_W'(head_cmd.value);
          cnt_r <= CNT_W'(1);
        end
        KIND_LEAD: begin
          acc_r <= CP_W'(head_cmd.value);
          len_r <= head_cmd.len;
        end
        KIND_CONT: begin
          acc_r <= acc_nxt;
          if (head_cmd.last) begin
            cp_r  <= acc_nxt;
            cnt_r <= len_r;
          end
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// utf8_stream_decoder: top level of the UTF-8 byte stream decoder (six-byte
// form). Depends on utf8d_pkg, utf8d_ifs, utf8d_front, utf8d_queue, utf8d_back.
//
//   channel  | dir | payload                     | handshake
//   ---------+-----+-----------------------------+------------
//   in_ch    | in  | data_byte[7:0]              | valid/ready
//   out_ch   | out | code_point[30:0], byte_count| valid/ready
//
// One byte is taken every cycle unless the queue is full; after its last byte is
// taken, a result passes through a queue entry, then the back end's output register.
// in_ch.ready drops only when the request queue (Q_DEPTH entries) is full.
// A stalled output holds its result while further lead and continuation
// bytes keep flowing into the queue and accumulator.
// Reset is synchronous and leaves no sequence open; no clearing pass.

module utf8_stream_decoder #(
  parameter int Q_DEPTH = 2
) (
  input logic         clk,
  input logic         rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch
);
  import utf8d_pkg::*;

  logic       q_full;
  logic       push;
  logic       pop;
  logic       head_vld;
  utf8d_cmd_t push_cmd;
  utf8d_cmd_t head_cmd;

  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_ch.valid),
    .byte_in  (in_ch.data_byte),
    .q_full   (q_full),
    .byte_rdy (in_ch.ready),
    .push     (push),
    .cmd      (push_cmd)
  );

  utf8d_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .head_vld (head_vld),
    .head_cmd (head_cmd)
  );

  utf8d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head_cmd (head_cmd),
    .pop      (pop),
    .res_vld  (out_ch.valid),
    .res_rdy  (out_ch.ready),
    .res_cp   (out_ch.code_point),
    .res_cnt  (out_ch.byte_count)
  );

endmodule

// ===== design/utf8d_checker.sv =====
// utf8d_checker: port-level assertions for utf8_stream_decoder and the bind
// that attaches them. Depends on utf8d_pkg and the top level's ports.

module utf8d_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [utf8d_pkg::CP_W-1:0]    out_code_point,
  input logic [utf8d_pkg::CNT_W-1:0]   out_byte_count
);
  import utf8d_pkg::*;

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
                                && $stable(out_byte_count))
    else $error("result changed while stalled");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count != '0 && out_byte_count <= CNT_W'(6))
    else $error("byte_count out of range");

  // single-byte results are ASCII or the invalid marker
  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == CNT_W'(1) |-> out_code_point[CP_W-1:7] == '0)
    else $error("single-byte result above 0x7F");

  // two-byte sequences carry at most 11 payload bits
  a_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == CNT_W'(2) |-> out_code_point[CP_W-1:11] == '0)
    else $error("two-byte result wider than 11 bits");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_code_point (out_ch.code_point),
  .out_byte_count (out_ch.byte_count)
);

// ===== tb/sv/utf8_stream_decoder_test.sv =====
// utf8_stream_decoder_test: self-checking bench for the UTF-8 stream decoder.
// Sends directed and random byte streams and checks each code point against a
// local decoder. Depends on utf8d_pkg, utf8d_ifs and utf8_stream_decoder.
`timescale 1ns / 100ps

module utf8_stream_decoder_test;
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  utf8d_in_if  in_ch ();
  utf8d_out_if out_ch ();

  utf8_stream_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local decoder state
  logic [CP_W-1:0]  seq_value;
  logic [CNT_W-1:0] seq_left;
  logic [CNT_W-1:0] seq_len;
  cp_result_t       pending_cps[$];
  int               err_count = 0;

  // stimulus pacing
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_seq     = 0;
  int stall_seen    = 0;
  int stall_cycles  = 0;
  int hold_left     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the code point that a request byte completes, if any.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    cp_result_t r;
    logic       opened;
    opened = 1'b0;
    if (seq_left != 0) begin
      seq_value = {seq_value[CP_W-7:0], b[5:0]};
      seq_left  = seq_left - 1'b1;
      if (seq_left == 0) begin
        r.code_point = seq_value;
        r.byte_count = seq_len;
        pending_cps.push_back(r);
        seq_value = '0;
        seq_len   = '0;
      end
    end else if (!b[7]) begin
      r.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
      r.byte_count = 3'd1;
      pending_cps.push_back(r);
    end else if (!b[6] || b[7:1] == 7'b1111111) begin
      // stray continuation, or 0xFE / 0xFF
      r.code_point = '0;
      r.byte_count = 3'd1;
      pending_cps.push_back(r);
    end else begin
      opened = 1'b1;
      if (!b[5]) begin
        seq_value = {{(CP_W-5){1'b0}}, b[4:0]};
        seq_len   = 3'd2;
      end else if (!b[4]) begin
        seq_value = {{(CP_W-4){1'b0}}, b[3:0]};
        seq_len   = 3'd3;
      end else if (!b[3]) begin
        seq_value = {{(CP_W-3){1'b0}}, b[2:0]};
        seq_len   = 3'd4;
      end else if (!b[2]) begin
        seq_value = {{(CP_W-2){1'b0}}, b[1:0]};
        seq_len   = 3'd5;
      end else begin
        seq_value = {{(CP_W-1){1'b0}}, b[0]};
        seq_len   = 3'd6;
      end
    end
    if (opened) seq_left = seq_len - 1'b1;
  endtask

  // Predict on accepted requests, then check accepted results, same edge.
  always @(posedge clk) begin
    cp_result_t exp_r;
    if (!rst_n) begin
      seq_value = '0;
      seq_left  = '0;
      seq_len   = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_cps.size() == 0) begin
          $error("unexpected result: code_point %0h byte_count %0d",
                 out_ch.code_point, out_ch.byte_count);
          err_count++;
        end else begin
          exp_r = pending_cps.pop_front();
          if (out_ch.code_point !== exp_r.code_point) begin
            $error("code_point: expected %0h, actual %0h", exp_r.code_point,
                   out_ch.code_point);
            err_count++;
          end
          if (out_ch.byte_count !== exp_r.byte_count) begin
            $error("byte_count: expected %0d, actual %0d", exp_r.byte_count,
                   out_ch.byte_count);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver: random idling, plus long hold-offs requested by the tests.
  always @(posedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen   <= stall_seq;
      hold_left    <= stall_cycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering requests, then wait until every predicted result has been checked.
  task automatic wait_for_pending_cps();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);  // stray continuation
    send_byte(8'hBF);
    send_byte(8'hFE);
    send_byte(8'hFF);
  endtask

  task automatic test_lead_sequences();
    send_byte(8'hDF); send_byte(8'hBF);
    send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
    // continuations with wrong top bits still count
    send_byte(8'hF8); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hC0);
    send_byte(8'h7F);
    // six bytes: all 31 bits set
    send_byte(8'hFD);
    repeat (5) send_byte(8'hBF);
  endtask

  task automatic send_random_sequence(output int n_sent);
    int                len;
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] cont;
    n_sent = 0;
    if ($urandom_range(99) < 12) begin
      send_byte(BYTE_W'($urandom_range(255)));
      n_sent = 1;
    end else begin
      len  = $urandom_range(1, 6);
      lead = BYTE_W'($urandom_range(255));
      case (len)
        1: lead[7]   = 1'b0;
        2: lead[7:5] = 3'b110;
        3: lead[7:4] = 4'b1110;
        4: lead[7:3] = 5'b11110;
        5: lead[7:2] = 6'b111110;
        default: lead[7:1] = 7'b1111110;
      endcase
      send_byte(lead);
      n_sent = 1;
      for (int i = 1; i < len; i++) begin
        cont = BYTE_W'($urandom_range(255));
        if ($urandom_range(99) >= 8) cont[7:6] = 2'b10;
        send_byte(cont);
        n_sent++;
      end
    end
  endtask

  task automatic test_random_text(input int n_items);
    int total;
    int n;
    total = 0;
    while (total < n_items) begin
      send_random_sequence(n);
      total += n;
    end
  endtask

  // Hold the output off while ASCII requests keep coming, so the queue fills.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_cycles <= 60;
    stall_seq    <= stall_seq + 1;
    @(posedge clk);
    repeat (24) send_byte({1'b0, 7'($urandom_range(127))});
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_bytes();
    test_lead_sequences();
    wait_for_pending_cps();

    send_idle_pct = 26;
    recv_idle_pct <= 55;
    test_random_text(200);
    wait_for_pending_cps();

    send_idle_pct = 55;
    recv_idle_pct <= 26;
    test_random_text(200);
    wait_for_pending_cps();

    recv_idle_pct <= 0;
    test_output_backpressure();
    wait_for_pending_cps();

    send_idle_pct = 0;
    test_random_text(200);
    in_ch.valid <= 1'b0;
    wait_for_pending_cps();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
